/* hw/rtl/vrp_pkg.sv */
// ----------------------------------------------------------------------------
// vrp_pkg
// shared constants, register codes and access kinds of the video register port
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int TABLE_COLUMNS = 32;
    localparam int TABLE_ROWS    = 30;
    localparam int TILE_COUNT    = TABLE_ROWS * TABLE_COLUMNS;
    localparam int STORE_COLUMNS = 2 * TABLE_COLUMNS;
    localparam int STORE_ROWS    = 2 * TABLE_ROWS;
    localparam int STORE_DEPTH   = STORE_ROWS * STORE_COLUMNS;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int VRAM_DEPTH    = 16384;
    localparam int VRAM_AW       = $clog2(VRAM_DEPTH);

    localparam logic [7:0] CTRL_VBLANK_MASK = 8'h40;
    localparam int         CTRL_STEP_BIT    = 2;

    typedef enum logic {
        MODE_READ  = 1'b0,
        MODE_WRITE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_index_t;

endpackage

/* hw/rtl/video_register_port_with_vram_map.sv */
// ----------------------------------------------------------------------------
// video_register_port_with_vram_map
// After reset the block zeroes video memory and the name-table store, one
// entry per cycle, and takes no transaction meanwhile. A data-port read
// (register 7) first passes through a read state, as the video and
// name-table rams have a registered read port; other accesses need none.
// Results pass through a result stage and an output register, so a new access
// is taken while a finished result still waits on the master side.
// ----------------------------------------------------------------------------
module video_register_port_with_vram_map
    import vrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // mirroring_vertical
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // write_data
    input  logic [3:0]  s_tuser,     // mode, reg_index[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata      // read_data, scroll_horizontal, scroll_vertical
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t              state_reg, state_next;
    logic [VRAM_AW-1:0]  clear_cnt_reg, clear_cnt_next;
    logic                mirror_reg, mirror_next;
    logic [7:0]          ctrl_reg, ctrl_next;
    logic [7:0]          mask_reg, mask_next;
    logic [7:0]          status_reg, status_next;
    logic [7:0]          oam_cnt_reg, oam_cnt_next;
    logic [7:0]          addr_byte_reg, addr_byte_next;
    logic                toggle_reg, toggle_next;
    logic [15:0]         vaddr_reg, vaddr_next;
    logic [7:0]          hscroll_reg, hscroll_next;
    logic [7:0]          vscroll_reg, vscroll_next;
    logic                sel_store_reg, sel_store_next;
    logic                res_valid_reg, res_valid_next;
    logic [23:0]         res_data_reg, res_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [23:0]         out_data_reg, out_data_next;

    mode_t               in_mode;
    reg_index_t          in_reg;
    logic                move;
    logic                accept;
    logic                data_write;
    logic [7:0]          rd_byte;
    logic [15:0]         step;

    logic [VRAM_AW-1:0]  a;
    logic [1:0]          quad;
    logic [9:0]          off;
    logic                tile;
    logic                mirror_nt;
    logic                pal_rep;
    logic                pal_mirror;
    logic [5:0]          row_full;
    logic [5:0]          row_top;
    logic [5:0]          col_full;
    logic [5:0]          col_left;
    logic [VRAM_AW-1:0]  vaddr_map;
    logic [VRAM_AW-1:0]  vaddr_rd;
    logic [STORE_AW-1:0] store_addr_wr;
    logic [STORE_AW-1:0] store_addr_rd;

    logic                video_we;
    logic [VRAM_AW-1:0]  video_waddr;
    logic [7:0]          video_wdata;
    logic [7:0]          video_rdata;
    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic [7:0]          store_wdata;
    logic [7:0]          store_rdata;

    assign in_mode = mode_t'(s_tuser[0]);
    assign in_reg  = reg_index_t'(s_tuser[3:1]);

    assign move     = res_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) && (!res_valid_reg || move);
    assign accept   = s_tvalid && s_tready;
    assign data_write = accept && (in_mode == MODE_WRITE) && (in_reg == REG_DATA);
    assign step     = ctrl_reg[CTRL_STEP_BIT] ? 16'(TABLE_COLUMNS) : 16'd1;

    // vram address map
    assign a          = vaddr_reg[VRAM_AW-1:0];
    assign quad       = a[11:10];
    assign off        = a[9:0];
    assign tile       = (a[13:12] == 2'b10) && (off < 10'(TILE_COUNT));
    assign mirror_nt  = (a[13:12] == 2'b11) && (a[11:8] != 4'hF);
    assign pal_rep    = (a[13:8] == 6'h3F) && (a[7:5] != 3'd0);
    assign pal_mirror = (a[13:4] == 10'h3F1) && (a[1:0] == 2'b00);
    assign row_top    = {1'b0, off[9:5]};
    assign row_full   = row_top + (quad[1] ? 6'(TABLE_ROWS) : 6'd0);
    assign col_full   = {quad[0], off[4:0]};
    assign col_left   = {1'b0, off[4:0]};
    assign store_addr_wr = {row_full, col_full};
    assign store_addr_rd = mirror_reg ? {row_top, col_full} : {row_full, col_left};

    always_comb
    begin
        if (mirror_nt)
        begin
            vaddr_map = {2'b10, a[11:0]};
        end
        else if (pal_rep)
        begin
            vaddr_map = {6'h3F, 3'b000, a[4:0]};
        end
        else
        begin
            vaddr_map = a;
        end
        vaddr_rd = pal_mirror ? {a[13:5], 1'b0, a[3:0]} : vaddr_map;
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            video_we    = 1'b1;
            video_waddr = clear_cnt_reg;
            video_wdata = 8'd0;
            store_we    = clear_cnt_reg < VRAM_AW'(STORE_DEPTH);
            store_waddr = clear_cnt_reg[STORE_AW-1:0];
            store_wdata = 8'd0;
        end
        else
        begin
            video_we    = data_write;
            video_waddr = vaddr_map;
            video_wdata = s_tdata;
            store_we    = data_write && tile;
            store_waddr = store_addr_wr;
            store_wdata = s_tdata;
        end
    end

    vrp_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_video_ram (
        .clk   (clk),
        .we    (video_we),
        .waddr (video_waddr),
        .wdata (video_wdata),
        .raddr (vaddr_rd),
        .rdata (video_rdata)
    );

    vrp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_addr_rd),
        .rdata (store_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        mirror_next    = cfg_we ? cfg_wdata : mirror_reg;
        ctrl_next      = ctrl_reg;
        mask_next      = mask_reg;
        status_next    = status_reg;
        oam_cnt_next   = oam_cnt_reg;
        addr_byte_next = addr_byte_reg;
        toggle_next    = toggle_reg;
        vaddr_next     = vaddr_reg;
        hscroll_next   = hscroll_reg;
        vscroll_next   = vscroll_reg;
        sel_store_next = sel_store_reg;
        rd_byte        = 8'd0;
        res_valid_next = res_valid_reg && !move;
        res_data_next  = res_data_reg;
        out_valid_next = move ? 1'b1 : (out_valid_reg && !m_tready);
        out_data_next  = move ? res_data_reg : out_data_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == {VRAM_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_READ)
                    begin
                        case (in_reg)
                            REG_CTRL:
                            begin
                                ctrl_next = ctrl_reg | CTRL_VBLANK_MASK;
                                rd_byte   = ctrl_next;
                            end
                            REG_MASK:     rd_byte = mask_reg;
                            REG_STATUS:   rd_byte = status_reg;
                            REG_OAM_ADDR: rd_byte = oam_cnt_reg;
                            REG_ADDR:     rd_byte = addr_byte_reg;
                            REG_DATA:
                            begin
                                sel_store_next = tile;
                                vaddr_next     = vaddr_reg + step;
                                state_next     = ST_READ;
                            end
                            default:      rd_byte = 8'd0;
                        endcase
                    end
                    else
                    begin
                        case (in_reg)
                            REG_CTRL:     ctrl_next = s_tdata;
                            REG_MASK:     mask_next = s_tdata;
                            REG_STATUS:   status_next = s_tdata;
                            REG_OAM_DATA: oam_cnt_next = oam_cnt_reg + 8'd1;
                            REG_SCROLL:
                            begin
                                if (toggle_reg)
                                begin
                                    vscroll_next = s_tdata;
                                end
                                else
                                begin
                                    hscroll_next = s_tdata;
                                end
                                toggle_next = !toggle_reg;
                            end
                            REG_ADDR:
                            begin
                                if (toggle_reg)
                                begin
                                    vaddr_next = {vaddr_reg[15:8], s_tdata};
                                end
                                else
                                begin
                                    vaddr_next = {s_tdata, vaddr_reg[7:0]};
                                end
                                addr_byte_next = s_tdata;
                                toggle_next    = !toggle_reg;
                            end
                            REG_DATA:     vaddr_next = vaddr_reg + step;
                            default:      ;
                        endcase
                    end
                    if (!((in_mode == MODE_READ) && (in_reg == REG_DATA)))
                    begin
                        res_valid_next = 1'b1;
                        res_data_next  = {vscroll_next, hscroll_next, rd_byte};
                    end
                end
            end
            ST_READ:
            begin
                res_valid_next = 1'b1;
                res_data_next  = {vscroll_reg, hscroll_reg,
                                  sel_store_reg ? store_rdata : video_rdata};
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            mirror_reg    <= 1'b0;
            ctrl_reg      <= 8'd0;
            mask_reg      <= 8'd0;
            status_reg    <= 8'd0;
            oam_cnt_reg   <= 8'd0;
            addr_byte_reg <= 8'd0;
            toggle_reg    <= 1'b0;
            vaddr_reg     <= 16'd0;
            hscroll_reg   <= 8'd0;
            vscroll_reg   <= 8'd0;
            sel_store_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            mirror_reg    <= mirror_next;
            ctrl_reg      <= ctrl_next;
            mask_reg      <= mask_next;
            status_reg    <= status_next;
            oam_cnt_reg   <= oam_cnt_next;
            addr_byte_reg <= addr_byte_next;
            toggle_reg    <= toggle_next;
            vaddr_reg     <= vaddr_next;
            hscroll_reg   <= hscroll_next;
            vscroll_reg   <= vscroll_next;
            sel_store_reg <= sel_store_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/vrp_ram.sv */
// ----------------------------------------------------------------------------
// vrp_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module vrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/vrp_checker.sv */
// ----------------------------------------------------------------------------
// vrp_checker
// port-level assertions for the video register port, bound to the top level
// ----------------------------------------------------------------------------
module vrp_checker
    import vrp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [3:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // no transaction right after a reset edge
    assert property (@(posedge clk)
        !rst_n |=> !s_tready)
        else $error("input ready right after reset");

    // a data-port read holds off the next transaction while it waits on the ram
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == MODE_READ) && (s_tuser[3:1] == REG_DATA))
        |=> !s_tready)
        else $error("transaction taken during data-port read");

    // no result right after reset
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind video_register_port_with_vram_map vrp_checker u_vrp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the video register port against a predictor kept in this module.
// A clocked driver sends register accesses from a queue. At each accepted
// transaction it computes the expected read data and scroll bytes. A clocked
// monitor compares every result with the oldest expectation. The stimulus is
// a directed part, then random bursts: set the address, write VRAM, set it
// again, read VRAM back. Random single accesses fill the gaps. The mirroring
// register is changed between phases while the port is idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;

    typedef struct packed {
        mode_t      mode;
        reg_index_t idx;
        logic [7:0] data;
    } access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] scroll_horizontal;
        logic [7:0] scroll_vertical;
    } port_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // write_data
    logic [3:0]  s_tuser = 4'h0;    // mode, reg_index[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // read_data, scroll_horizontal, scroll_vertical

    access_t      pending_access[$];
    port_result_t awaited_result[$];
    access_t      offered_access;
    port_result_t oldest_result;
    int           idle_pct = 6;
    int           stall_pct = 6;
    int           error_count = 0;
    int           quiet_cycles = 0;
    int           queued_count = 0;
    bit           gen_toggle = 1'b0;

    // predicted state of the port
    bit          mirroring_vertical = 1'b0;
    bit [7:0]    port_bytes [8];
    bit          write_toggle = 1'b0;
    bit [15:0]   vram_address = 16'h0000;
    bit [7:0]    hscroll = 8'h00;
    bit [7:0]    vscroll = 8'h00;
    bit [7:0]    video_mem [VRAM_DEPTH];
    bit [7:0]    name_store [STORE_DEPTH];

    video_register_port_with_vram_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic bit name_table_cell(input int a, output int row, output int col);
        int quad;
        int offs;
        row = 0;
        col = 0;
        if (a < 'h2000 || a > 'h2FFF)
            return 1'b0;
        quad = (a >> 10) & 3;
        offs = a & 'h3FF;
        if (offs >= TILE_COUNT)
            return 1'b0;
        row = offs / TABLE_COLUMNS + (quad >> 1) * TABLE_ROWS;
        col = offs % TABLE_COLUMNS + (quad & 1) * TABLE_COLUMNS;
        return 1'b1;
    endfunction

    function automatic logic [7:0] vram_fetch(input int a);
        int row;
        int col;
        a = a & (VRAM_DEPTH - 1);
        if ((a & 'hFFF3) == 'h3F10)
            return video_mem[a - 'h10];
        if (name_table_cell(a, row, col))
        begin
            if (mirroring_vertical)
                row = row % TABLE_ROWS;
            else
                col = col % TABLE_COLUMNS;
            return name_store[row * STORE_COLUMNS + col];
        end
        if (a >= 'h3000 && a <= 'h3EFF)
            return video_mem[a - 'h1000];
        if (a >= 'h3F20)
            return video_mem['h3F00 + (a - 'h3F20) % 32];
        return video_mem[a];
    endfunction

    function automatic void vram_store(input int a, input logic [7:0] d);
        int row;
        int col;
        a = a & (VRAM_DEPTH - 1);
        if (a >= 'h3000 && a <= 'h3EFF)
            a = a - 'h1000;
        else if (name_table_cell(a, row, col))
            name_store[row * STORE_COLUMNS + col] = d;
        else if (a >= 'h3F20)
            a = 'h3F00 + (a - 'h3F20) % 32;
        video_mem[a] = d;
    endfunction

    function automatic port_result_t step_register_port(input access_t acc);
        port_result_t r;
        r.read_data = 8'h00;
        if (acc.mode == MODE_READ)
        begin
            case (acc.idx)
                REG_CTRL:
                begin
                    port_bytes[REG_CTRL] = port_bytes[REG_CTRL] | CTRL_VBLANK_MASK;
                    r.read_data = port_bytes[REG_CTRL];
                end
                REG_STATUS:
                begin
                    port_bytes[REG_SCROLL] = 8'h00;
                    r.read_data = port_bytes[REG_STATUS];
                end
                REG_DATA:
                    r.read_data = vram_fetch(int'(vram_address));
                default:
                    r.read_data = port_bytes[acc.idx];
            endcase
        end
        else
        begin
            case (acc.idx)
                // a sprite address write has no effect; sprite data writes only count up
                REG_OAM_ADDR:
                    ;
                REG_OAM_DATA:
                    port_bytes[REG_OAM_ADDR] = port_bytes[REG_OAM_ADDR] + 8'd1;
                REG_SCROLL:
                begin
                    if (!write_toggle)
                        hscroll = acc.data;
                    else
                        vscroll = acc.data;
                    write_toggle = ~write_toggle;
                end
                REG_ADDR:
                begin
                    if (!write_toggle)
                        vram_address[15:8] = acc.data;
                    else
                        vram_address[7:0] = acc.data;
                    port_bytes[REG_ADDR] = acc.data;
                    write_toggle = ~write_toggle;
                end
                REG_DATA:
                    vram_store(int'(vram_address), acc.data);
                default:
                    port_bytes[acc.idx] = acc.data;
            endcase
        end
        if (acc.idx == REG_DATA)
            vram_address = vram_address + (port_bytes[REG_CTRL][CTRL_STEP_BIT] ? 16'd32 : 16'd1);
        r.scroll_horizontal = hscroll;
        r.scroll_vertical = vscroll;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                awaited_result.push_back(step_register_port(offered_access));
            if (!s_tvalid || s_tready)
            begin
                if (pending_access.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    offered_access = pending_access.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= offered_access.data;
                    s_tuser <= {offered_access.idx, offered_access.mode};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %02h actual %02h", $time, label, want, got);
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (awaited_result.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected transaction, expected none actual %06h",
                             $time, m_tdata);
                end
                else
                begin
                    oldest_result = awaited_result.pop_front();
                    check_field("read_data", oldest_result.read_data, m_tdata[7:0]);
                    check_field("scroll_horizontal", oldest_result.scroll_horizontal,
                                m_tdata[15:8]);
                    check_field("scroll_vertical", oldest_result.scroll_vertical,
                                m_tdata[23:16]);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic push_access(input mode_t mode, input reg_index_t idx, input logic [7:0] data);
        access_t acc;
        acc.mode = mode;
        acc.idx = idx;
        acc.data = data;
        pending_access.push_back(acc);
        queued_count++;
        if (mode == MODE_WRITE && (idx == REG_SCROLL || idx == REG_ADDR))
            gen_toggle = ~gen_toggle;
    endtask

    task automatic queue_address(input logic [15:0] a);
        if (gen_toggle)
            push_access(MODE_WRITE, REG_SCROLL, 8'($urandom_range(255)));
        push_access(MODE_WRITE, REG_ADDR, a[15:8]);
        push_access(MODE_WRITE, REG_ADDR, a[7:0]);
    endtask

    function automatic logic [15:0] pick_vram_address();
        logic [15:0] a;
        case ($urandom_range(9))
            0, 1, 2, 3: a = 16'h2000 + 16'($urandom_range('hFFF));
            4:          a = 16'h23C0 + 16'($urandom_range(3) << 10)
                            + 16'($urandom_range(63));
            5:          a = 16'h3000 + 16'($urandom_range('hEFF));
            6:          a = 16'h3F00 + 16'($urandom_range('hFF));
            7:          a = 16'($urandom_range('h1FFF));
            8:          a = 16'h3F10 + 16'($urandom_range(3) << 2);
            default:    a = 16'($urandom_range('hFFFF));
        endcase
        if ($urandom_range(3) == 0)
            a[15:14] = 2'($urandom_range(3));
        return a;
    endfunction

    task automatic run_random(input int count);
        int          target;
        int          burst_len;
        logic [15:0] base;
        target = queued_count + count;
        while (queued_count < target)
        begin
            if ($urandom_range(9) < 7)
            begin
                base = pick_vram_address();
                burst_len = $urandom_range(1, 8);
                if ($urandom_range(9) < 3)
                    push_access(MODE_WRITE, REG_CTRL, 8'($urandom_range(255)));
                queue_address(base);
                repeat (burst_len)
                    push_access(MODE_WRITE, REG_DATA, 8'($urandom_range(255)));
                // read back at the same place or through another quadrant
                if ($urandom_range(1))
                    base[11:10] = 2'($urandom_range(3));
                queue_address(base);
                repeat (burst_len)
                    push_access(MODE_READ, REG_DATA, 8'($urandom_range(255)));
            end
            else
                push_access(mode_t'($urandom_range(1)), reg_index_t'($urandom_range(7)),
                            8'($urandom_range(255)));
        end
    endtask

    task automatic wait_idle();
        while (pending_access.size() != 0 || s_tvalid || awaited_result.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_mirroring(input bit vertical);
        wait_idle();
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= vertical;
        mirroring_vertical = vertical;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_mirroring(1'b0);
        push_access(MODE_READ, REG_CTRL, 8'hFF);
        push_access(MODE_WRITE, REG_MASK, 8'hFF);
        push_access(MODE_READ, REG_MASK, 8'h00);
        push_access(MODE_WRITE, REG_STATUS, 8'hA5);
        push_access(MODE_READ, REG_STATUS, 8'h5A);
        push_access(MODE_WRITE, REG_OAM_ADDR, 8'hFF);
        push_access(MODE_WRITE, REG_OAM_DATA, 8'h00);
        push_access(MODE_WRITE, REG_OAM_DATA, 8'hFF);
        push_access(MODE_READ, REG_OAM_ADDR, 8'h00);
        push_access(MODE_READ, REG_OAM_DATA, 8'h00);
        // status read between the two scroll writes keeps the toggle
        push_access(MODE_WRITE, REG_SCROLL, 8'hFF);
        push_access(MODE_READ, REG_STATUS, 8'h00);
        push_access(MODE_WRITE, REG_SCROLL, 8'h00);
        // address wraps from 0xffff, top bits ignored on access
        queue_address(16'hFFFF);
        push_access(MODE_WRITE, REG_DATA, 8'h00);
        push_access(MODE_READ, REG_DATA, 8'h00);
        // step by 32
        push_access(MODE_WRITE, REG_CTRL, 8'h04);
        queue_address(16'h3F00);
        push_access(MODE_WRITE, REG_DATA, 8'h77);
        push_access(MODE_READ, REG_DATA, 8'h00);
        queue_address(16'h3F10);
        push_access(MODE_READ, REG_DATA, 8'h00);
        queue_address(16'h2C05);
        push_access(MODE_WRITE, REG_DATA, 8'h5A);
        queue_address(16'h3C05);
        push_access(MODE_READ, REG_DATA, 8'h00);
        run_random(480);

        set_mirroring(1'b1);
        queue_address(16'h2405);
        push_access(MODE_READ, REG_DATA, 8'h00);
        queue_address(16'h2C05);
        push_access(MODE_READ, REG_DATA, 8'h00);
        queue_address(16'h23C0);
        push_access(MODE_WRITE, REG_DATA, 8'h3C);
        queue_address(16'h23C0);
        push_access(MODE_READ, REG_DATA, 8'h00);
        run_random(480);

        // long stretch with no idling on either side
        idle_pct = 0;
        stall_pct = 0;
        set_mirroring(1'b0);
        run_random(360);

        idle_pct = 6;
        stall_pct = 6;
        set_mirroring(1'b1);
        run_random(360);

        wait_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0 && awaited_result.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
